### rtl/kcg_pkg.sv
// package: shared types and constants of the k-combination generator
package kcg_pkg;

  localparam int VALUE_W    = 32;
  localparam int IDX_W      = 4;
  localparam int OP_W       = 2;
  localparam int POS_W      = 3;
  localparam int SET_SIZE_W = 5;
  localparam int CHOOSE_W   = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = SET_SIZE_W;

  localparam int DEF_MAX_ELEMENTS = 16;
  localparam int DEF_MAX_CHOOSE   = 8;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHOOSE   = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD    = 2'd0,
    OP_RESTART = 2'd1,
    OP_NEXT    = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_RESTART,
    CMD_NEXT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                  kind;
    logic [IDX_W-1:0]           index;
    logic signed [VALUE_W-1:0]  value;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_EMIT,
    ST_EXHAUST,
    ST_ADVANCE
  } st_t;

endpackage

### rtl/kcg_ifs.sv
// interfaces: request channel and result channel
interface kcg_in_if import kcg_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           operation;
  logic [IDX_W-1:0]          element_index;
  logic signed [VALUE_W-1:0] element_value;

  modport source (output valid, operation, element_index, element_value, input ready);
  modport sink (input valid, operation, element_index, element_value, output ready);
endinterface

interface kcg_out_if import kcg_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic [POS_W-1:0]          position;
  logic                      last_of_combination;
  logic                      exhausted;

  modport source (output valid, value, position, last_of_combination, exhausted,
                  input ready);
  modport sink (input valid, value, position, last_of_combination, exhausted,
                output ready);
endinterface

### rtl/kcg_ram.sv
// generic single write port ram with registered read
module kcg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/kcg_front.sv
// front end: accepts requests, drops ignored ones, queues commands
module kcg_front import kcg_pkg::*; #(
  parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS
) (
  kcg_in_if.sink  in_ch,
  input  logic    q_full,
  output logic    push,
  output cmd_t    push_cmd
);

  logic accept;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    push           = 1'b0;
    push_cmd.kind  = CMD_NEXT;
    push_cmd.index = in_ch.element_index;
    push_cmd.value = in_ch.element_value;
    case (in_ch.operation)
      OP_LOAD: begin
        push_cmd.kind = CMD_LOAD;
        push          = accept && (int'(in_ch.element_index) < MAX_ELEMENTS);
      end
      OP_RESTART: begin
        push_cmd.kind = CMD_RESTART;
        push          = accept;
      end
      OP_NEXT: begin
        push_cmd.kind = CMD_NEXT;
        push          = accept;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

endmodule

### rtl/kcg_queue.sv
// short command queue between front end and back end
module kcg_queue import kcg_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  output logic q_vld,
  output cmd_t q_cmd,
  input  logic pop
);

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign q_vld = (cnt_r != '0);
  assign q_cmd = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? wptr_r + QPTR_W'(1) : wptr_r;
    rptr_nxt = pop ? rptr_r + QPTR_W'(1) : rptr_r;
    cnt_nxt  = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_cmd;
    end
  end

endmodule

### rtl/kcg_back.sv
// back end: executes commands, walks and advances the combination cursor
module kcg_back import kcg_pkg::*; #(
  parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
  parameter int MAX_CHOOSE   = DEF_MAX_CHOOSE
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [$clog2(MAX_ELEMENTS + 1)-1:0]  n_eff,
  input  logic [$clog2(MAX_CHOOSE + 1)-1:0]    k_eff,
  input  logic                                 q_vld,
  input  cmd_t                                 q_cmd,
  output logic                                 q_pop,
  kcg_out_if.source                            out_ch
);

  localparam int AW   = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int KW   = $clog2(MAX_CHOOSE + 1);
  localparam int SW   = (MAX_CHOOSE > 1) ? $clog2(MAX_CHOOSE) : 1;
  localparam int CMAX = (MAX_ELEMENTS > MAX_CHOOSE) ? MAX_ELEMENTS : MAX_CHOOSE;
  localparam int CW   = $clog2(CMAX + 1);

  st_t                       st_r, st_nxt;
  logic [CW-1:0]             cur_r [MAX_CHOOSE];
  logic [CW-1:0]             cur_nxt [MAX_CHOOSE];
  logic                      done_r, done_nxt;
  logic [KW-1:0]             rd_pos_r, rd_pos_nxt;
  logic                      d_vld_r, d_vld_nxt;
  logic [KW-1:0]             d_pos_r, d_pos_nxt;
  logic                      out_vld_r, out_vld_nxt;
  logic signed [VALUE_W-1:0] out_val_r, out_val_nxt;
  logic [POS_W-1:0]          out_pos_r, out_pos_nxt;
  logic                      out_last_r, out_last_nxt;
  logic                      out_exh_r, out_exh_nxt;

  logic                      cur_ok;
  logic                      adv_found;
  logic [SW-1:0]             adv_sel;
  logic [CW-1:0]             adv_base;
  logic                      out_free;
  logic                      take;
  logic                      issue;
  logic                      emit_end;
  logic                      ram_we;
  logic [AW-1:0]             ram_raddr;
  logic [VALUE_W-1:0]        ram_rdata;

  kcg_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (MAX_ELEMENTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(q_cmd.index)),
    .wdata (q_cmd.value),
    .re    (issue),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // cursor check: k not above n, cursor ascending and below n
  always_comb begin
    cur_ok = (int'(k_eff) <= int'(n_eff));
    for (int i = 0; i < MAX_CHOOSE; i++) begin
      if (i < int'(k_eff) && int'(cur_r[i]) >= int'(n_eff)) begin
        cur_ok = 1'b0;
      end
    end
    for (int i = 1; i < MAX_CHOOSE; i++) begin
      if (i < int'(k_eff) && cur_r[i] <= cur_r[i-1]) begin
        cur_ok = 1'b0;
      end
    end
  end

  // rightmost index that can still move
  always_comb begin
    adv_found = 1'b0;
    adv_sel   = '0;
    for (int p = 0; p < MAX_CHOOSE; p++) begin
      if (p < int'(k_eff) && int'(cur_r[p]) + int'(k_eff) < int'(n_eff) + p) begin
        adv_found = 1'b1;
        adv_sel   = SW'(p);
      end
    end
    adv_base = cur_r[adv_sel] + CW'(1);
  end

  assign out_free  = !out_vld_r || out_ch.ready;
  assign q_pop     = (st_r == ST_IDLE) && q_vld;
  assign ram_we    = q_pop && (q_cmd.kind == CMD_LOAD);
  assign take      = (st_r == ST_EMIT) && d_vld_r && out_free;
  assign issue     = (st_r == ST_EMIT) && (rd_pos_r < k_eff) && (!d_vld_r || take);
  assign emit_end  = (st_r == ST_EMIT) && (rd_pos_r == k_eff) && (!d_vld_r || take);
  assign ram_raddr = AW'(cur_r[rd_pos_r[SW-1:0]]);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (q_pop && q_cmd.kind == CMD_NEXT) begin
          st_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        st_nxt = (done_r || !cur_ok) ? ST_EXHAUST : ST_EMIT;
      end
      ST_EXHAUST: begin
        if (out_free) begin
          st_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (emit_end) begin
          st_nxt = ST_ADVANCE;
        end
      end
      ST_ADVANCE: begin
        st_nxt = ST_IDLE;
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cur_nxt      = cur_r;
    done_nxt     = done_r;
    rd_pos_nxt   = rd_pos_r;
    d_vld_nxt    = d_vld_r;
    d_pos_nxt    = d_pos_r;
    out_vld_nxt  = out_vld_r && !out_ch.ready;
    out_val_nxt  = out_val_r;
    out_pos_nxt  = out_pos_r;
    out_last_nxt = out_last_r;
    out_exh_nxt  = out_exh_r;
    case (st_r)
      ST_IDLE: begin
        if (q_pop && q_cmd.kind == CMD_RESTART) begin
          for (int i = 0; i < MAX_CHOOSE; i++) begin
            cur_nxt[i] = CW'(i);
          end
          done_nxt = 1'b0;
        end
      end
      ST_CHECK: begin
        rd_pos_nxt = '0;
        d_vld_nxt  = 1'b0;
        if (done_r || !cur_ok) begin
          done_nxt = 1'b1;
        end
      end
      ST_EXHAUST: begin
        if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_val_nxt  = '0;
          out_pos_nxt  = '0;
          out_last_nxt = 1'b0;
          out_exh_nxt  = 1'b1;
        end
      end
      ST_EMIT: begin
        if (take) begin
          out_vld_nxt  = 1'b1;
          out_val_nxt  = ram_rdata;
          out_pos_nxt  = POS_W'(d_pos_r);
          out_last_nxt = (d_pos_r + KW'(1) == k_eff);
          out_exh_nxt  = 1'b0;
          d_vld_nxt    = 1'b0;
        end
        if (issue) begin
          d_vld_nxt  = 1'b1;
          d_pos_nxt  = rd_pos_r;
          rd_pos_nxt = rd_pos_r + KW'(1);
        end
      end
      ST_ADVANCE: begin
        if (adv_found) begin
          for (int j = 0; j < MAX_CHOOSE; j++) begin
            if (j > int'(adv_sel) && j < int'(k_eff)) begin
              cur_nxt[j] = CW'(int'(adv_base) + j - int'(adv_sel));
            end
          end
          cur_nxt[adv_sel] = adv_base;
        end else begin
          done_nxt = 1'b1;
        end
      end
      default: begin
        done_nxt = done_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      done_r    <= 1'b0;
      rd_pos_r  <= '0;
      d_vld_r   <= 1'b0;
      d_pos_r   <= '0;
      out_vld_r <= 1'b0;
      for (int i = 0; i < MAX_CHOOSE; i++) begin
        cur_r[i] <= CW'(i);
      end
    end else begin
      st_r      <= st_nxt;
      done_r    <= done_nxt;
      rd_pos_r  <= rd_pos_nxt;
      d_vld_r   <= d_vld_nxt;
      d_pos_r   <= d_pos_nxt;
      out_vld_r <= out_vld_nxt;
      cur_r     <= cur_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_val_r  <= out_val_nxt;
    out_pos_r  <= out_pos_nxt;
    out_last_r <= out_last_nxt;
    out_exh_r  <= out_exh_nxt;
  end

  assign out_ch.valid               = out_vld_r;
  assign out_ch.value               = out_val_r;
  assign out_ch.position            = out_pos_r;
  assign out_ch.last_of_combination = out_last_r;
  assign out_ch.exhausted           = out_exh_r;

  a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (take || (st_r == ST_EXHAUST && out_free)) |-> (!out_vld_r || out_ch.ready))
    else $error("result register overwritten while stalled");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (st_r == ST_IDLE))
    else $error("queue popped outside idle");

  a_pending_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    d_vld_r |-> (d_pos_r < k_eff && st_r == ST_EMIT))
    else $error("pending read position out of range");

  a_emit_ends_in_advance: assert property (@(posedge clk) disable iff (!rst_n)
    emit_end |=> (st_r == ST_ADVANCE && !d_vld_r))
    else $error("emission did not end in cursor advance");

endmodule

### rtl/k_combination_generator.sv
// top level: k-combination generator with config registers, front end, queue, back end
//
// requests arrive on in_ch: load writes element_value at element_index, restart
// sets the cursor to 0,1,2,... and next emits the current combination.
// results leave on out_ch: a next request gives k results (value, position,
// last_of_combination marked on the final one) or a single exhausted result.
// set_size and choose_count must be written on the cfg port only while the block
// is idle; the block itself does not enforce this. the back end finishes a load
// or restart request at its pop; a next request runs through pop, cursor check,
// k element reads from the element memory's single read port plus a drain of the
// last read, and a cursor advance; a next request that finds no combination
// left runs through pop, check and an exhausted result.
// a two-entry queue lets in_ch keep accepting while the back end works.
// when out_ch stalls the result register holds and the back end waits;
// once the queue is full in_ch.ready drops.
// reset (rst_n low, synchronous) empties the queue, sets the cursor to
// 0,1,2,..., clears the exhausted state and sets both registers to 1.
// element memory contents are not cleared; load an entry before it is read.
module k_combination_generator import kcg_pkg::*; #(
  parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
  parameter int MAX_CHOOSE   = DEF_MAX_CHOOSE
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  kcg_in_if.sink                in_ch,
  kcg_out_if.source             out_ch
);

  localparam int NW = $clog2(MAX_ELEMENTS + 1);
  localparam int KW = $clog2(MAX_CHOOSE + 1);

  logic [SET_SIZE_W-1:0] set_size_r, set_size_nxt;
  logic [CHOOSE_W-1:0]   choose_r, choose_nxt;
  logic [NW-1:0]         n_eff;
  logic [KW-1:0]         k_eff;
  logic                  push;
  cmd_t                  push_cmd;
  logic                  q_full;
  logic                  q_vld;
  cmd_t                  q_cmd;
  logic                  q_pop;

  always_comb begin
    set_size_nxt = set_size_r;
    choose_nxt   = choose_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_SET_SIZE: set_size_nxt = cfg_data;
        CFG_CHOOSE:   choose_nxt   = cfg_data[CHOOSE_W-1:0];
        default:      set_size_nxt = set_size_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_size_r <= SET_SIZE_W'(1);
      choose_r   <= CHOOSE_W'(1);
    end else begin
      set_size_r <= set_size_nxt;
      choose_r   <= choose_nxt;
    end
  end

  // saturate registers to the supported range
  always_comb begin
    if (set_size_r == '0) begin
      n_eff = NW'(1);
    end else if (int'(set_size_r) > MAX_ELEMENTS) begin
      n_eff = NW'(MAX_ELEMENTS);
    end else begin
      n_eff = NW'(set_size_r);
    end
    if (choose_r == '0) begin
      k_eff = KW'(1);
    end else if (int'(choose_r) > MAX_CHOOSE) begin
      k_eff = KW'(MAX_CHOOSE);
    end else begin
      k_eff = KW'(choose_r);
    end
  end

  kcg_front #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_front (
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  kcg_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .q_vld    (q_vld),
    .q_cmd    (q_cmd),
    .pop      (q_pop)
  );

  kcg_back #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .MAX_CHOOSE   (MAX_CHOOSE)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .n_eff  (n_eff),
    .k_eff  (k_eff),
    .q_vld  (q_vld),
    .q_cmd  (q_cmd),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

endmodule

### dv/k_combination_generator_tb.sv
`timescale 1ns / 1ps
// testbench: k-combination generator checked request by request against a shadow enumerator
module k_combination_generator_tb;
  import kcg_pkg::*;

  localparam int CLK_PERIOD      = 20;
  localparam int DRAIN_CYCLES    = 24;
  localparam int RANDOM_REQUESTS = 195;
  localparam int LIMIT_CYCLES    = 400_000;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]           op;
    logic [IDX_W-1:0]          idx;
    logic signed [VALUE_W-1:0] val;
  } request_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;
    logic                      last;
    logic                      exhausted;
  } element_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  kcg_in_if  in_ch ();
  kcg_out_if out_ch ();

  k_combination_generator i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // shadow state of the enumerator
  logic signed [VALUE_W-1:0] shadow_elements [DEF_MAX_ELEMENTS];
  logic [IDX_W-1:0]          shadow_cursor [DEF_MAX_CHOOSE];
  logic                      shadow_done;
  logic [SET_SIZE_W-1:0]     shadow_set_size;
  logic [CHOOSE_W-1:0]       shadow_choose;

  request_t        pending_requests [$];
  element_result_t due_results [$];
  request_t        current_request;
  int              error_count;
  int              gap_left;
  int              ready_left;
  bit              steady;

  function automatic void restart_cursor();
    for (int i = 0; i < DEF_MAX_CHOOSE; i++) begin
      shadow_cursor[i] = IDX_W'(i);
    end
  endfunction

  function automatic void step_enumerator(request_t req);
    int              n;
    int              k;
    int              p;
    bit              cursor_ok;
    element_result_t r;
    n = (shadow_set_size < 1) ? 1 :
        (shadow_set_size > DEF_MAX_ELEMENTS) ? DEF_MAX_ELEMENTS : int'(shadow_set_size);
    k = (shadow_choose < 1) ? 1 :
        (shadow_choose > DEF_MAX_CHOOSE) ? DEF_MAX_CHOOSE : int'(shadow_choose);
    case (req.op)
      OP_LOAD: begin
        shadow_elements[req.idx] = req.val;
      end
      OP_RESTART: begin
        restart_cursor();
        shadow_done = 1'b0;
      end
      OP_NEXT: begin
        cursor_ok = !shadow_done && (k <= n);
        for (p = 0; p < k; p++) begin
          if (shadow_cursor[p] >= n) begin
            cursor_ok = 1'b0;
          end else if (p > 0) begin
            if (shadow_cursor[p] <= shadow_cursor[p-1]) cursor_ok = 1'b0;
          end
        end
        if (!cursor_ok) begin
          shadow_done = 1'b1;
          r.value = '0;
          r.position = '0;
          r.last = 1'b0;
          r.exhausted = 1'b1;
          due_results.push_back(r);
        end else begin
          for (p = 0; p < k; p++) begin
            r.value = shadow_elements[shadow_cursor[p]];
            r.position = POS_W'(p);
            r.last = (p == k - 1);
            r.exhausted = 1'b0;
            due_results.push_back(r);
          end
          // rightmost index with room to grow, then refill after it
          p = k - 1;
          while (p >= 0 && shadow_cursor[p] >= n - k + p) p--;
          if (p < 0) begin
            shadow_done = 1'b1;
          end else begin
            shadow_cursor[p] = shadow_cursor[p] + 1'b1;
            for (int j = p + 1; j < k; j++) begin
              shadow_cursor[j] = shadow_cursor[p] + IDX_W'(j - p);
            end
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic int draw_idle();
    int roll;
    roll = $urandom_range(0, 9);
    if (steady || roll < 6) return 0;
    if (roll < 9) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  function automatic logic signed [VALUE_W-1:0] random_value();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return -1;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_request(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                               logic signed [VALUE_W-1:0] val);
    request_t req;
    req.op = op;
    req.idx = idx;
    req.val = val;
    pending_requests.push_back(req);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_requests.size() != 0 || in_ch.valid || due_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(logic [SET_SIZE_W-1:0] n, logic [CHOOSE_W-1:0] k);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_SET_SIZE;
    cfg_data <= n;
    @(posedge clk);
    cfg_index <= CFG_CHOOSE;
    cfg_data <= CFG_DATA_W'(k);
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_set_size = n;
    shadow_choose = k;
  endtask

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.operation = '0;
    in_ch.element_index = '0;
    in_ch.element_value = '0;
    out_ch.ready = 1'b0;
    shadow_done = 1'b0;
    shadow_set_size = SET_SIZE_W'(1);
    shadow_choose = CHOOSE_W'(1);
    restart_cursor();
    error_count = 0;
    steady = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) step_enumerator(current_request);
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left != 0) begin
          in_ch.valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_requests.size() != 0) begin
          current_request = pending_requests.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.operation <= current_request.op;
          in_ch.element_index <= current_request.idx;
          in_ch.element_value <= current_request.val;
          gap_left <= draw_idle();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : monitor
    element_result_t got;
    element_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      ready_left <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.value = out_ch.value;
        got.position = out_ch.position;
        got.last = out_ch.last_of_combination;
        got.exhausted = out_ch.exhausted;
        if (due_results.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, %s %0d pos %0d last %0b exh %0b",
                   $time, "actual value", got.value, got.position, got.last,
                   got.exhausted);
          error_count++;
        end else begin
          want = due_results.pop_front();
          if (got !== want) begin
            $display("%0t ns: mismatch, expected value %0d pos %0d last %0b exh %0b,",
                     $time, want.value, want.position, want.last, want.exhausted);
            $display("  actual value %0d pos %0d last %0b exh %0b",
                     got.value, got.position, got.last, got.exhausted);
            error_count++;
          end
        end
      end
      if (ready_left == 0) begin
        if (steady) begin
          out_ch.ready <= 1'b1;
        end else begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
              out_ch.ready <= 1'b1;
              ready_left <= $urandom_range(0, 6);
            end
            6, 7, 8: begin
              out_ch.ready <= 1'b0;
              ready_left <= $urandom_range(0, 3);
            end
            default: begin
              out_ch.ready <= 1'b0;
              ready_left <= $urandom_range(10, 30);
            end
          endcase
        end
      end else begin
        ready_left <= ready_left - 1;
      end
    end
  end

  initial begin : stimulus
    int                    sent;
    int                    roll;
    logic [SET_SIZE_W-1:0] n_pick;
    logic [CHOOSE_W-1:0]   k_pick;
    wait (rst_n === 1'b1);
    @(posedge clk);

    // every element loaded before any read, edge values first
    queue_request(OP_LOAD, 4'd0, 32'sh8000_0000);
    queue_request(OP_LOAD, 4'd1, 32'sh7fff_ffff);
    queue_request(OP_LOAD, 4'd2, '0);
    queue_request(OP_LOAD, 4'd3, -1);
    for (int i = 4; i < DEF_MAX_ELEMENTS; i++) queue_request(OP_LOAD, IDX_W'(i), $urandom);
    queue_request(OP_NEXT, '0, '0);
    queue_request(OP_NEXT, '0, '0);
    queue_request(OP_UNUSED, 4'd15, -1);
    queue_request(OP_RESTART, '0, '0);
    wait_idle();
    set_config(5'd16, 4'd8);
    queue_request(OP_NEXT, '0, '0);
    wait_idle();
    // saturated registers
    set_config(5'd31, 4'd15);
    queue_request(OP_NEXT, '0, '0);
    wait_idle();
    set_config(5'd0, 4'd0);
    queue_request(OP_NEXT, '0, '0);
    wait_idle();
    // k above n
    set_config(5'd3, 4'd7);
    queue_request(OP_NEXT, '0, '0);

    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      wait_idle();
      n_pick = SET_SIZE_W'(($urandom_range(0, 9) < 7) ? $urandom_range(1, 7) :
                                                        $urandom_range(0, 31));
      k_pick = CHOOSE_W'(($urandom_range(0, 9) < 7) ? $urandom_range(1, 4) :
                                                      $urandom_range(0, 15));
      set_config(n_pick, k_pick);
      steady = ($urandom_range(0, 3) == 0);
      // without a restart the old cursor may be stale for the new sizes
      if ($urandom_range(0, 4) != 0) begin
        queue_request(OP_RESTART, IDX_W'($urandom), $urandom);
        sent++;
      end
      repeat ($urandom_range(3, 14)) begin
        roll = $urandom_range(0, 19);
        if (roll < 15) begin
          queue_request(OP_NEXT, IDX_W'($urandom), $urandom);
        end else if (roll < 17) begin
          queue_request(OP_LOAD, IDX_W'($urandom), random_value());
        end else if (roll < 18) begin
          queue_request(OP_RESTART, IDX_W'($urandom), $urandom);
        end else begin
          queue_request(OP_UNUSED, IDX_W'($urandom), $urandom);
        end
        sent++;
      end
    end
    wait_idle();
    if (error_count == 0) begin
      $display("k_combination_generator test passed");
    end else begin
      $display("k_combination_generator test failed");
    end
    $finish;
  end

  initial begin
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("k_combination_generator test failed");
    $finish;
  end

endmodule
